@@ rtl/otsu_threshold_to_zero_assert.svh @@
// Assertion macros for the Otsu threshold block.
`ifndef OTSU_THRESHOLD_TO_ZERO_ASSERT_SVH
`define OTSU_THRESHOLD_TO_ZERO_ASSERT_SVH

`ifndef SYNTHESIS
`define OTSU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define OTSU_ASSERT_IMPL(label, ante, cons, msg)
`endif

`ifndef SYNTHESIS
`define OTSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OTSU_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/otsu_pkg.sv @@
package otsu_pkg;

  localparam int unsigned LEVELS     = 256;
  localparam int unsigned MAX_PIXELS = 1048576;

  localparam int unsigned CNT_W  = 21;  // bin and pixel counts
  localparam int unsigned SUM_W  = 28;  // grey level sums
  localparam int unsigned PROD_W = 49;  // S1*n0 and S0*n1
  localparam int unsigned PAIR_W = 42;  // n0*n1
  localparam int unsigned SQ_W   = 98;  // d*d
  localparam int unsigned MX_W   = SQ_W;
  localparam int unsigned MY_W   = PROD_W;
  localparam int unsigned MP_W   = MX_W + MY_W;

  localparam logic FUNC_ACC     = 1'b0;
  localparam logic FUNC_APPLY   = 1'b1;
  localparam logic KIND_REPORT  = 1'b0;
  localparam logic KIND_PIXEL   = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] pixel;
    logic       last;
  } otsu_item_t;

endpackage

@@ rtl/otsu_front.sv @@
module otsu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [7:0]         pixel_i,
  input  logic               last_i,
  output otsu_pkg::otsu_item_t q_item_o,
  output logic               q_valid_o,
  input  logic               q_pop_i
);
  import otsu_pkg::*;

  otsu_item_t q_mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (count_q != 2'd0);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= '{func: func_i, pixel: pixel_i, last: last_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      unique case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ rtl/otsu_mul.sv @@
module otsu_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [otsu_pkg::MX_W-1:0] x_i,
  input  logic [otsu_pkg::MY_W-1:0] y_i,
  output logic                      done_o,
  output logic [otsu_pkg::MP_W-1:0] prod_o
);
  import otsu_pkg::*;

  localparam int unsigned CW = $clog2(MY_W + 1);

  logic [MP_W-1:0] acc_q, mcand_q;
  logic [MY_W-1:0] mplier_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q;

  assign done_o = busy_q && (cnt_q == '0);
  assign prod_o = acc_q;

  // Shift-and-add, one multiplier bit per cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= MP_W'(x_i);
      mplier_q <= y_i;
    end else if (busy_q && cnt_q != '0) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(MY_W);
    end else if (busy_q) begin
      if (cnt_q == '0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

@@ rtl/otsu_back.sv @@
module otsu_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  otsu_pkg::otsu_item_t q_item_i,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 kind_o,
  output logic [7:0]           threshold_o,
  output logic [7:0]           pixel_out_o
);
  import otsu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_SUM, S_PRE, S_C1, S_C2, S_SQ, S_LHS, S_RHS, S_NEXT, S_FIN
  } state_e;

  state_e state_q;

  // Histogram memory with per-bin valid flags, so a frame end clears it at once.
  logic [CNT_W-1:0] hist_mem [LEVELS];
  logic [LEVELS-1:0] bin_vld_q;
  logic [CNT_W-1:0] rd_q;
  logic             rd_vld_q;
  logic [7:0]       ra;
  logic             we;
  logic [CNT_W-1:0] hist_rd;

  otsu_item_t       cur_q;
  logic [CNT_W-1:0] total_q;
  logic [7:0]       held_q;

  logic [8:0]       cnt_q;
  logic             proc_vld_q;
  logic [7:0]       proc_idx_q;
  logic             found_q;
  logic [7:0]       lo_q, hi_q, t_q, best_t_q;
  logic [CNT_W-1:0] lo_h_q, n_all_q, n0_q, hist_t_q;
  logic [SUM_W-1:0] s_all_q, s0_q;
  logic [PROD_W-1:0] a_q, b_q, d;
  logic [PAIR_W-1:0] p_q, best_p_q;
  logic [SQ_W-1:0]  sq_q, best_sq_q;
  logic [MP_W-1:0]  lhs_q;
  logic             have_q;

  logic             mul_start, mul_done;
  logic [MX_W-1:0]  mul_x;
  logic [MY_W-1:0]  mul_y;
  logic [MP_W-1:0]  mul_prod;

  logic             out_valid_q, kind_q;
  logic [7:0]       thr_q, pix_q;
  logic             slot_free;
  logic             out_load;

  assign hist_rd   = rd_vld_q ? rd_q : '0;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign d         = (a_q > b_q) ? (a_q - b_q) : '0;
  assign out_load  = (state_q == S_IDLE && q_pop_o && q_item_i.func == FUNC_APPLY) ||
                     (state_q == S_FIN && slot_free);

  otsu_mul u_mul (
    .clk_i, .rst_ni,
    .start_i (mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  always_comb begin
    ra        = q_item_i.pixel;
    we        = (state_q == S_ACC);
    q_pop_o   = 1'b0;
    mul_start = 1'b0;
    mul_x     = MX_W'(d);
    mul_y     = d;
    unique case (state_q)
      S_IDLE: q_pop_o = q_valid_i && (q_item_i.func == FUNC_ACC || slot_free);
      S_ACC:  ra = cur_q.pixel;
      S_SUM:  ra = cnt_q[7:0];
      S_C1:   ra = t_q;
      S_C2:   mul_start = (d != '0) && (p_q != '0);
      S_SQ: begin
        mul_x     = mul_prod[SQ_W-1:0];
        mul_y     = MY_W'(best_p_q);
        mul_start = mul_done && have_q;
      end
      S_LHS: begin
        mul_x     = best_sq_q;
        mul_y     = MY_W'(p_q);
        mul_start = mul_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) hist_mem[cur_q.pixel] <= hist_rd + 1'b1;
    rd_q <= hist_mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bin_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      total_q     <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_REPORT;
      thr_q       <= '0;
      pix_q       <= '0;
      cur_q       <= '0;
      cnt_q       <= '0;
      proc_vld_q  <= 1'b0;
      proc_idx_q  <= '0;
      found_q     <= 1'b0;
      have_q      <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      t_q         <= '0;
      best_t_q    <= '0;
      lo_h_q      <= '0;
      n_all_q     <= '0;
      n0_q        <= '0;
      hist_t_q    <= '0;
      s_all_q     <= '0;
      s0_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      p_q         <= '0;
      best_p_q    <= '0;
      sq_q        <= '0;
      best_sq_q   <= '0;
      lhs_q       <= '0;
    end else begin
      rd_vld_q <= bin_vld_q[ra];
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (q_pop_o) begin
            cur_q <= q_item_i;
            if (q_item_i.func == FUNC_APPLY) begin
              kind_q      <= KIND_PIXEL;
              thr_q       <= held_q;
              pix_q       <= (q_item_i.pixel > held_q) ? q_item_i.pixel : 8'd0;
            end else if (total_q < CNT_W'(MAX_PIXELS)) begin
              state_q <= S_ACC;
            end else if (q_item_i.last) begin
              state_q    <= S_SUM;
              cnt_q      <= '0;
              proc_vld_q <= 1'b0;
              found_q    <= 1'b0;
              n_all_q    <= '0;
              s_all_q    <= '0;
            end
          end
        end
        S_ACC: begin
          bin_vld_q[cur_q.pixel] <= 1'b1;
          total_q <= total_q + 1'b1;
          if (cur_q.last) begin
            state_q    <= S_SUM;
            cnt_q      <= '0;
            proc_vld_q <= 1'b0;
            found_q    <= 1'b0;
            n_all_q    <= '0;
            s_all_q    <= '0;
          end else begin
            state_q <= S_IDLE;
          end
        end
        // One bin per cycle: occupied range, total count and grey sum.
        S_SUM: begin
          proc_vld_q <= !cnt_q[8];
          proc_idx_q <= cnt_q[7:0];
          cnt_q      <= cnt_q + 1'b1;
          if (proc_vld_q && hist_rd != '0) begin
            if (!found_q) begin
              found_q <= 1'b1;
              lo_q    <= proc_idx_q;
              lo_h_q  <= hist_rd;
            end
            hi_q    <= proc_idx_q;
            n_all_q <= n_all_q + hist_rd;
            s_all_q <= s_all_q + SUM_W'(hist_rd) * SUM_W'(proc_idx_q);
          end
          if (cnt_q[8]) state_q <= S_PRE;
        end
        S_PRE: begin
          have_q   <= 1'b0;
          best_t_q <= '0;
          n0_q     <= lo_h_q;
          s0_q     <= SUM_W'(lo_h_q) * SUM_W'(lo_q);
          t_q      <= lo_q + 8'd1;
          if (!found_q || ({1'b0, lo_q} + 9'd1 >= {1'b0, hi_q})) state_q <= S_FIN;
          else state_q <= S_C1;
        end
        S_C1: begin
          a_q     <= PROD_W'(s_all_q - s0_q) * PROD_W'(n0_q);
          b_q     <= PROD_W'(s0_q) * PROD_W'(n_all_q - n0_q);
          p_q     <= PAIR_W'(n0_q) * PAIR_W'(n_all_q - n0_q);
          state_q <= S_C2;
        end
        S_C2: begin
          hist_t_q <= hist_rd;
          state_q  <= mul_start ? S_SQ : S_NEXT;
        end
        S_SQ: begin
          if (mul_done) begin
            sq_q <= mul_prod[SQ_W-1:0];
            if (!have_q) begin
              have_q    <= 1'b1;
              best_sq_q <= mul_prod[SQ_W-1:0];
              best_p_q  <= p_q;
              best_t_q  <= t_q;
              state_q   <= S_NEXT;
            end else begin
              state_q <= S_LHS;
            end
          end
        end
        S_LHS: begin
          if (mul_done) begin
            lhs_q   <= mul_prod;
            state_q <= S_RHS;
          end
        end
        S_RHS: begin
          if (mul_done) begin
            if (lhs_q > mul_prod) begin
              best_sq_q <= sq_q;
              best_p_q  <= p_q;
              best_t_q  <= t_q;
            end
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          n0_q <= n0_q + hist_t_q;
          s0_q <= s0_q + SUM_W'(hist_t_q) * SUM_W'(t_q);
          t_q  <= t_q + 8'd1;
          if ({1'b0, t_q} + 9'd1 < {1'b0, hi_q}) state_q <= S_C1;
          else state_q <= S_FIN;
        end
        S_FIN: begin
          if (slot_free) begin
            kind_q      <= KIND_REPORT;
            thr_q       <= best_t_q;
            pix_q       <= '0;
            held_q      <= best_t_q;
            bin_vld_q   <= '0;
            total_q     <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign threshold_o = thr_q;
  assign pixel_out_o = pix_q;

endmodule

@@ rtl/otsu_threshold_to_zero.sv @@
// Channel  Handshake                Payload
// in       in_valid_i / in_stall_o  func_i, pixel_i, last_i
// out      out_valid_o / out_stall_i kind_o, threshold_o, pixel_out_o
//
// An applied pixel is registered at the output as it is popped from the queue, one per
// cycle while the back end is idle and the output is free, and an accumulated pixel holds
// the back end for the read-modify-write of the histogram memory. A frame end costs a bin
// sweep plus, per candidate threshold, up to 3 serial multiplications.
// A two-entry request queue lets the input keep flowing while the back end works.
// Reset is asynchronous and clears the histogram through per-bin valid flags.
module otsu_threshold_to_zero (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       func_i,
  input  logic [7:0] pixel_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic [7:0] threshold_o,
  output logic [7:0] pixel_out_o
);
  import otsu_pkg::*;

  `include "otsu_threshold_to_zero_assert.svh"

  otsu_item_t q_item;
  logic       q_valid, q_pop;

  otsu_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .func_i, .pixel_i, .last_i,
    .q_item_o  (q_item),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop)
  );

  otsu_back u_back (
    .clk_i, .rst_ni,
    .q_item_i  (q_item),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .out_valid_o, .out_stall_i,
    .kind_o, .threshold_o, .pixel_out_o
  );

  `OTSU_ASSERT_IMPL(a_report_zero, out_valid_o && kind_o == KIND_REPORT, pixel_out_o == 8'd0, "report carries a nonzero pixel")
  `OTSU_ASSERT_IMPL(a_pass_above, out_valid_o && kind_o == KIND_PIXEL && pixel_out_o != 8'd0, pixel_out_o > threshold_o, "passed pixel not above threshold")
  `OTSU_ASSERT_NEXT(a_hold_stall, out_valid_o && out_stall_i, out_valid_o && $stable(threshold_o), "result dropped under stall")

endmodule

@@ sim/otsu_threshold_to_zero_tb.sv @@
module otsu_threshold_to_zero_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import otsu_pkg::*;

  typedef struct packed {
    logic       func;
    logic [7:0] pixel;
    logic       last;
  } pixel_req_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] threshold;
    logic [7:0] pixel_out;
  } otsu_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       func_i = 1'b0;
  logic [7:0] pixel_i = 8'd0;
  logic       last_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       kind_o;
  logic [7:0] threshold_o;
  logic [7:0] pixel_out_o;

  otsu_threshold_to_zero u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  pixel_req_t   pending_reqs[$];
  otsu_result_t expected_results[$];
  int unsigned  bin_count[LEVELS];
  int unsigned  frame_count;
  logic [7:0]   cur_threshold;
  int unsigned  sent_count;
  int unsigned  errors;
  int unsigned  idle_phase;

  function automatic logic [191:0] spread_term(longint unsigned d, longint unsigned p);
    return 192'(d) * 192'(d) * 192'(p);
  endfunction

  // Exact Otsu search over the collected histogram.
  function automatic logic [7:0] otsu_pick();
    int lo, hi;
    longint unsigned n_all, s_all, n0, s0, n1, s1, a, b, d, p, best_d, best_p;
    bit have;
    int best_t;
    lo = -1; hi = -1; n_all = 0; s_all = 0; best_d = 0; best_p = 1;
    have = 0; best_t = 0;
    for (int v = 0; v < LEVELS; v++) begin
      if (bin_count[v] != 0) begin
        if (lo < 0) lo = v;
        hi = v;
        n_all += bin_count[v];
        s_all += longint'(bin_count[v]) * v;
      end
    end
    if (lo < 0) return 8'd0;
    n0 = bin_count[lo];
    s0 = longint'(bin_count[lo]) * lo;
    for (int t = lo + 1; t <= hi - 1; t++) begin
      n1 = n_all - n0;
      s1 = s_all - s0;
      a = s1 * n0;
      b = s0 * n1;
      d = (a > b) ? a - b : 0;
      p = n0 * n1;
      if (d != 0 && p != 0) begin
        if (!have || spread_term(d, best_p) > spread_term(best_d, p)) begin
          have = 1; best_d = d; best_p = p; best_t = t;
        end
      end
      n0 += bin_count[t];
      s0 += longint'(bin_count[t]) * t;
    end
    return best_t[7:0];
  endfunction

  task automatic predict_otsu(input pixel_req_t req);
    otsu_result_t res;
    if (req.func == FUNC_APPLY) begin
      res.kind = KIND_PIXEL;
      res.threshold = cur_threshold;
      res.pixel_out = (req.pixel > cur_threshold) ? req.pixel : 8'd0;
      expected_results.push_back(res);
    end else begin
      if (frame_count < MAX_PIXELS) begin
        bin_count[req.pixel]++;
        frame_count++;
      end
      if (req.last) begin
        cur_threshold = otsu_pick();
        foreach (bin_count[i]) bin_count[i] = 0;
        frame_count = 0;
        res.kind = KIND_REPORT;
        res.threshold = cur_threshold;
        res.pixel_out = 8'd0;
        expected_results.push_back(res);
      end
    end
  endtask

  function automatic bit roll(input int unsigned pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_req_t req;
    bit idle;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_otsu('{func_i, pixel_i, last_i});
        sent_count++;
      end
      if (!in_valid_i || !in_stall_o) begin
        idle = (idle_phase == 1) ? roll(76) : (idle_phase == 3) ? roll(14) : 1'b0;
        if (pending_reqs.size() != 0 && !idle) begin
          req = pending_reqs.pop_front();
          func_i <= req.func;
          pixel_i <= req.pixel;
          last_i <= req.last;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      idle_phase <= (sent_count / 60) % 4;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    otsu_result_t got, want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = '{kind_o, threshold_o, pixel_out_o};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result kind=%0d thr=%0d pix=%0d", $time,
                   got.kind, got.threshold, got.pixel_out);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.kind != want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            errors++;
          end
          if (got.threshold != want.threshold) begin
            $display("%0t: threshold expected %0d actual %0d", $time,
                     want.threshold, got.threshold);
            errors++;
          end
          if (got.pixel_out != want.pixel_out) begin
            $display("%0t: pixel_out expected %0d actual %0d", $time,
                     want.pixel_out, got.pixel_out);
            errors++;
          end
        end
      end
      out_stall_i <= (idle_phase == 2) ? roll(76) : (idle_phase == 3) ? roll(14) : 1'b0;
    end
  end

  task automatic add_req(input logic func, input logic [7:0] pix, input logic last);
    pixel_req_t req;
    req.func = func; req.pixel = pix; req.last = last;
    pending_reqs.push_back(req);
  endtask

  task automatic add_applies(input int n);
    for (int i = 0; i < n; i++)
      add_req(FUNC_APPLY, 8'($urandom_range(255, 0)), 1'($urandom));
  endtask

  // One frame of pixels spread over span levels above base.
  task automatic add_frame(input int len, input int base, input int span);
    for (int i = 0; i < len; i++)
      add_req(FUNC_ACC, 8'(base + $urandom_range(span, 0)), i == len - 1);
  endtask

  initial begin
    int len, span;
    foreach (bin_count[i]) bin_count[i] = 0;
    frame_count = 0; cur_threshold = 8'd0; sent_count = 0; errors = 0; idle_phase = 0;

    // Threshold is zero out of reset.
    add_req(FUNC_APPLY, 8'd0, 1'b0);
    add_req(FUNC_APPLY, 8'd255, 1'b1);
    add_req(FUNC_APPLY, 8'd1, 1'b0);
    // A single occupied level gives no candidate.
    add_frame(1, 8'd77, 0);
    add_req(FUNC_APPLY, 8'd77, 1'b0);
    // Two adjacent levels leave no candidate either.
    add_req(FUNC_ACC, 8'd10, 1'b0);
    add_req(FUNC_ACC, 8'd11, 1'b1);
    // Both extremes: every level between is a candidate.
    add_req(FUNC_ACC, 8'd0, 1'b0);
    add_req(FUNC_ACC, 8'd255, 1'b0);
    add_req(FUNC_ACC, 8'd255, 1'b0);
    add_req(FUNC_ACC, 8'd128, 1'b1);
    add_req(FUNC_APPLY, 8'd255, 1'b0);
    add_req(FUNC_APPLY, 8'd0, 1'b1);
    add_applies(4);
    // Three levels with a tie in the variance.
    add_req(FUNC_ACC, 8'd20, 1'b0);
    add_req(FUNC_ACC, 8'd22, 1'b0);
    add_req(FUNC_ACC, 8'd24, 1'b1);
    add_applies(3);

    while (pending_reqs.size() < 750) begin
      len = $urandom_range(30, 1);
      if (roll(4)) begin
        add_frame(len, 0, 255);
      end else begin
        span = $urandom_range(14, 0);
        add_frame(len, $urandom_range(255 - span, 0), span);
      end
      add_applies($urandom_range(25, 2));
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_reqs.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("otsu_threshold_to_zero: match");
    end else begin
      $display("otsu_threshold_to_zero: mismatch");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("otsu_threshold_to_zero: mismatch");
    $finish;
  end

endmodule
